// ----- hdl/mles_pkg.sv -----
// ----------------------------------------------------------------------------
// mles_pkg
// Shared types, constants and helpers of the loop event store.
// ----------------------------------------------------------------------------
`default_nettype none

package mles_pkg;

    localparam int STORE_DEPTH_DEF = 64;
    localparam int RESULT_LIMIT    = 64;
    localparam int RES_W           = $clog2(RESULT_LIMIT + 1);

    localparam int POS_W    = 32;
    localparam int RATE_W   = 18;
    localparam int TEMPO_W  = 18;
    localparam int OFFSET_W = 24;
    localparam int SCALE_W  = 17;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = RATE_W'(48000);
    localparam logic [TEMPO_W-1:0] TEMPO_RST       = TEMPO_W'(30720);

    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_DECAY  = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO       = 2'd2;

    localparam logic [3:0] NOTE_ON_HI = 4'h9;

    typedef struct packed {
        logic [1:0]          kind;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    window_end;
        logic [7:0]          msg_status;
        logic [6:0]          msg_data1;
        logic [6:0]          msg_data2;
        logic [SCALE_W-1:0]  scale;
    } t_in_word;

    typedef struct packed {
        logic                has_event;
        logic [OFFSET_W-1:0] sample_offset;
        logic [7:0]          out_status;
        logic [6:0]          out_data1;
        logic [6:0]          out_data2;
        logic                store_full;
        logic                last;
    } t_out_word;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [7:0]       status;
        logic [6:0]       data1;
        logic [6:0]       data2;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic is_note_on(input logic [7:0] st, input logic [6:0] vel);
        return (st[7:4] == NOTE_ON_HI) && (vel != 7'd0);
    endfunction

    function automatic logic [6:0] vel_scale(input logic [6:0] vel,
                                             input logic [SCALE_W-1:0] scale);
        logic [SCALE_W+6:0] prod;
        prod = vel * scale;
        return prod[22:16];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mles_chan_if.sv -----
// ----------------------------------------------------------------------------
// mles_chan_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mles_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/midi_loop_event_store.sv -----
// ----------------------------------------------------------------------------
// midi_loop_event_store
// Sorted store of looped three-byte MIDI events with record, window query,
// velocity decay and clear.
// ----------------------------------------------------------------------------
// Items are taken one at a time; every pass goes through one event RAM with
// a registered read. A record walks down from the last entry in the store,
// moving each entry with a later position up one place. A decay compacts the
// store. A query scans the store and waits on the sample offset divider for
// each matching event, plus any wait for the output to be taken. Clear and a
// record into a full store go straight to the finish state. No memory
// clearing pass is needed after reset. A finished word waits in the output
// register while the next item is taken.
`default_nettype none

module midi_loop_event_store #(
    parameter int STORE_DEPTH = mles_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mles_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mles_pkg::CFG_W-1:0]     i_cfg_data,
    mles_chan_if.sink                           i_in,
    mles_chan_if.source                         o_out
);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_FIN     = 4'd1;
    localparam logic [3:0] ST_REC_RD  = 4'd2;
    localparam logic [3:0] ST_REC_CMP = 4'd3;
    localparam logic [3:0] ST_REC_PUT = 4'd4;
    localparam logic [3:0] ST_Q_RD    = 4'd5;
    localparam logic [3:0] ST_Q_CMP   = 4'd6;
    localparam logic [3:0] ST_Q_WAIT  = 4'd7;
    localparam logic [3:0] ST_Q_END   = 4'd8;
    localparam logic [3:0] ST_D_RD    = 4'd9;
    localparam logic [3:0] ST_D_CMP   = 4'd10;

    logic [3:0]                          r_state;
    logic [CW-1:0]                       r_count;
    logic                                r_cleared;
    logic [mles_pkg::POS_W-1:0]          r_loop_len;
    logic [mles_pkg::RATE_W-1:0]         r_sample_rate;
    logic [mles_pkg::TEMPO_W-1:0]        r_tempo;
    mles_pkg::t_in_word                  r_in;
    logic [AW-1:0]                       r_idx;
    logic [AW-1:0]                       r_wa;
    logic                                r_full;
    logic                                r_have;
    logic                                r_off_ok;
    logic [mles_pkg::RES_W-1:0]          r_nres;
    mles_pkg::t_out_word                 r_cur;
    mles_pkg::t_out_word                 r_hold;
    mles_pkg::t_out_word                 r_out;
    logic                                r_out_valid;

    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    mles_pkg::t_entry                    ram_wdata;
    logic [mles_pkg::ENTRY_W-1:0]        ram_rdata;
    mles_pkg::t_entry                    rd;

    logic                                out_free;
    logic                                out_load;
    mles_pkg::t_out_word                 out_next;
    logic                                in_acc;
    logic                                last_idx;
    logic                                proceed;

    logic                                hit;
    logic                                rd_note;
    logic [6:0]                          rd_v;
    logic                                keep;
    logic [mles_pkg::POS_W+1:0]          diff;
    logic [mles_pkg::POS_W+1:0]          dwrap;
    logic [mles_pkg::POS_W-1:0]          delta;
    logic                                off_done;
    logic [mles_pkg::OFFSET_W-1:0]       off_value;

    mles_ram #(
        .WIDTH (mles_pkg::ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    mles_offset u_offset (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (r_state == ST_Q_CMP && hit),
        .i_delta       (delta),
        .i_sample_rate (r_sample_rate),
        .i_tempo       (r_tempo),
        .o_done        (off_done),
        .o_offset      (off_value)
    );

    assign rd       = mles_pkg::t_entry'(ram_rdata);
    assign out_free = !r_out_valid || o_out.ready;
    assign in_acc   = i_in.valid && i_in.ready;
    assign last_idx = (CW'(r_idx) + CW'(1)) == r_count;
    assign proceed  = (r_off_ok || off_done) && (!r_have || out_free);

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // window test and distance from window start
    always_comb begin
        if (r_in.position <= r_in.window_end) begin
            hit = (rd.position >= r_in.position) && (rd.position < r_in.window_end);
        end else begin
            hit = (rd.position >= r_in.position) || (rd.position < r_in.window_end);
        end
        diff  = {2'b00, rd.position} - {2'b00, r_in.position};
        dwrap = diff[mles_pkg::POS_W+1] ? diff + {2'b00, r_loop_len} : diff;
        delta = dwrap[mles_pkg::POS_W+1] ? '0 : dwrap[mles_pkg::POS_W-1:0];
        rd_note = mles_pkg::is_note_on(rd.status, rd.data2);
        rd_v    = mles_pkg::vel_scale(rd.data2, r_in.scale);
        keep    = !rd_note || (rd_v != 7'd0);
    end

    // ram write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx + 1'b1;
        ram_wdata = rd;
        case (r_state)
            ST_REC_CMP: begin
                ram_we = rd.position > r_in.position;
            end
            ST_REC_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_wa;
                ram_wdata = '{position: r_in.position, status: r_in.msg_status,
                              data1: r_in.msg_data1, data2: r_in.msg_data2};
            end
            ST_D_CMP: begin
                ram_we    = keep;
                ram_waddr = r_wa;
                if (rd_note) begin
                    ram_wdata.status = {mles_pkg::NOTE_ON_HI, rd.status[3:0]};
                    ram_wdata.data2  = rd_v;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // output word selection
    always_comb begin
        out_load      = 1'b0;
        out_next      = '0;
        out_next.last = 1'b1;
        case (r_state)
            ST_FIN: begin
                out_load            = out_free;
                out_next.store_full = r_full;
            end
            ST_Q_WAIT: begin
                out_load = proceed && r_have;
                out_next = r_hold;
            end
            ST_Q_END: begin
                out_load = out_free;
                if (r_have) begin
                    out_next      = r_hold;
                    out_next.last = 1'b1;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_cleared     <= 1'b0;
            r_loop_len    <= '0;
            r_sample_rate <= mles_pkg::SAMPLE_RATE_RST;
            r_tempo       <= mles_pkg::TEMPO_RST;
            r_out_valid   <= 1'b0;
            r_have        <= 1'b0;
            r_off_ok      <= 1'b0;
            r_full        <= 1'b0;
            r_nres        <= '0;
            r_idx         <= '0;
            r_wa          <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mles_pkg::CFG_LOOP_LENGTH: begin
                        r_loop_len <= i_cfg_data;
                        r_cleared  <= 1'b0;
                    end
                    mles_pkg::CFG_SAMPLE_RATE: begin
                        r_sample_rate <= i_cfg_data[mles_pkg::RATE_W-1:0];
                    end
                    mles_pkg::CFG_TEMPO: begin
                        r_tempo <= i_cfg_data[mles_pkg::TEMPO_W-1:0];
                    end
                    default: begin
                        r_tempo <= r_tempo;
                    end
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_in   <= i_in.payload;
                        r_full <= 1'b0;
                        r_have <= 1'b0;
                        r_nres <= '0;
                        r_idx  <= '0;
                        r_wa   <= '0;
                        unique case (i_in.payload.kind)
                            mles_pkg::KIND_RECORD: begin
                                if (r_count == CW'(STORE_DEPTH)) begin
                                    r_full  <= 1'b1;
                                    r_state <= ST_FIN;
                                end else if (r_count == '0) begin
                                    r_state <= ST_REC_PUT;
                                end else begin
                                    r_idx   <= AW'(r_count - 1'b1);
                                    r_state <= ST_REC_RD;
                                end
                            end
                            mles_pkg::KIND_QUERY: begin
                                if (r_count == '0 || r_loop_len == '0 || r_cleared) begin
                                    r_state <= ST_FIN;
                                end else begin
                                    r_state <= ST_Q_RD;
                                end
                            end
                            mles_pkg::KIND_DECAY: begin
                                if (i_in.payload.scale[mles_pkg::SCALE_W-1] ||
                                    r_count == '0) begin
                                    r_state <= ST_FIN;
                                end else begin
                                    r_state <= ST_D_RD;
                                end
                            end
                            mles_pkg::KIND_CLEAR: begin
                                r_count    <= '0;
                                r_loop_len <= '0;
                                r_cleared  <= 1'b1;
                                r_state    <= ST_FIN;
                            end
                            default: begin
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_REC_RD: begin
                    r_state <= ST_REC_CMP;
                end
                ST_REC_CMP: begin
                    if (rd.position > r_in.position) begin
                        if (r_idx == '0) begin
                            r_wa    <= '0;
                            r_state <= ST_REC_PUT;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= ST_REC_RD;
                        end
                    end else begin
                        r_wa    <= r_idx + 1'b1;
                        r_state <= ST_REC_PUT;
                    end
                end
                ST_REC_PUT: begin
                    r_count <= r_count + 1'b1;
                    r_state <= ST_FIN;
                end
                ST_Q_RD: begin
                    r_state <= ST_Q_CMP;
                end
                ST_Q_CMP: begin
                    r_off_ok <= 1'b0;
                    if (hit) begin
                        r_cur.has_event     <= 1'b1;
                        r_cur.sample_offset <= '0;
                        r_cur.out_data1     <= rd.data1;
                        r_cur.store_full    <= 1'b0;
                        r_cur.last          <= 1'b0;
                        if (rd_note && !r_in.scale[mles_pkg::SCALE_W-1]) begin
                            r_cur.out_status <= {mles_pkg::NOTE_ON_HI, rd.status[3:0]};
                            r_cur.out_data2  <= (rd_v == 7'd0) ? 7'd1 : rd_v;
                        end else begin
                            r_cur.out_status <= rd.status;
                            r_cur.out_data2  <= rd.data2;
                        end
                        r_state <= ST_Q_WAIT;
                    end else if (last_idx) begin
                        r_state <= ST_Q_END;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_Q_RD;
                    end
                end
                ST_Q_WAIT: begin
                    if (off_done) begin
                        r_off_ok <= 1'b1;
                    end
                    if (proceed) begin
                        r_hold <= '{has_event: r_cur.has_event, sample_offset: off_value,
                                    out_status: r_cur.out_status,
                                    out_data1: r_cur.out_data1,
                                    out_data2: r_cur.out_data2,
                                    store_full: r_cur.store_full, last: r_cur.last};
                        r_have <= 1'b1;
                        r_nres <= r_nres + 1'b1;
                        if (r_nres + 1'b1 == mles_pkg::RES_W'(mles_pkg::RESULT_LIMIT) ||
                            last_idx) begin
                            r_state <= ST_Q_END;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_Q_RD;
                        end
                    end
                end
                ST_Q_END: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_D_RD: begin
                    r_state <= ST_D_CMP;
                end
                ST_D_CMP: begin
                    if (keep) begin
                        r_wa <= r_wa + 1'b1;
                    end
                    if (last_idx) begin
                        r_count <= CW'(r_wa) + CW'(keep);
                        r_state <= ST_FIN;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_D_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // store never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STORE_DEPTH))
        else $error("event count above store depth");

    // no store writes while waiting for an item
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !ram_we)
        else $error("ram write while idle");

    // offset unit only finishes while a query waits for it
    a_offset_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        off_done |-> r_state == ST_Q_WAIT)
        else $error("offset done outside query wait");

    // query word count stays within the limit
    a_result_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= mles_pkg::RES_W'(mles_pkg::RESULT_LIMIT))
        else $error("too many query words");

    // a loaded word never overwrites one not yet taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output word overwritten");

endmodule

`default_nettype wire

// ----- hdl/mles_ram.sv -----
// ----------------------------------------------------------------------------
// mles_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mles_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ----- hdl/mles_offset.sv -----
// ----------------------------------------------------------------------------
// mles_offset
// Beat distance to sample offset: two multiply steps, then a bit-serial
// divide by the tempo, saturating to the offset width.
// ----------------------------------------------------------------------------
`default_nettype none

module mles_offset (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mles_pkg::POS_W-1:0]    i_delta,
    input  wire logic [mles_pkg::RATE_W-1:0]   i_sample_rate,
    input  wire logic [mles_pkg::TEMPO_W-1:0]  i_tempo,
    output logic                               o_done,
    output logic      [mles_pkg::OFFSET_W-1:0] o_offset
);
    localparam int P1_W  = mles_pkg::POS_W + mles_pkg::RATE_W;
    localparam int P2_W  = P1_W + 6;
    localparam int DIV_W = P2_W - 8;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int TW    = mles_pkg::TEMPO_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                      r_state;
    logic [mles_pkg::POS_W-1:0]      r_d;
    logic [mles_pkg::RATE_W-1:0]     r_sr;
    logic [TW-1:0]                   r_tempo;
    logic [P1_W-1:0]                 r_p1;
    logic [DIV_W-1:0]                r_num;
    logic [TW-1:0]                   r_rem;
    logic [mles_pkg::OFFSET_W-1:0]   r_q;
    logic                            r_ovf;
    logic [CNT_W-1:0]                r_cnt;

    logic [P2_W-1:0] prod60;
    logic [TW:0]     trial;
    logic            ge;

    assign prod60 = (P2_W'(r_p1) << 6) - (P2_W'(r_p1) << 2);
    assign trial  = {r_rem, r_num[DIV_W-1]};
    assign ge     = trial >= {1'b0, r_tempo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_d     <= i_delta;
                        r_sr    <= i_sample_rate;
                        r_tempo <= (i_tempo == '0) ? TW'(1) : i_tempo;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p1    <= r_d * r_sr;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_num   <= prod60[P2_W-1:8];
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_ovf   <= 1'b0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= ge ? TW'(trial - {1'b0, r_tempo}) : trial[TW-1:0];
                    r_num <= r_num << 1;
                    r_q   <= {r_q[mles_pkg::OFFSET_W-2:0], ge};
                    r_ovf <= r_ovf | r_q[mles_pkg::OFFSET_W-1];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_state == S_DONE);
    assign o_offset = r_ovf ? '1 : r_q;
endmodule

`default_nettype wire
